// ===== rtl/ced_pkg.sv =====
`default_nettype none

package ced_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Escape decode state; the code doubles as the count of held bytes
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_OPEN = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4
  } phase_t;

  // One classified input item: held bytes to replay, then an optional
  // plain byte, then an optional malformed backslash.
  typedef struct packed {
    logic [2:0] rep_len;
    logic [7:0] digit1;
    logic [7:0] digit2;
    logic       has_main;
    logic [7:0] main_byte;
    logic       tail_bs;
    logic       last;
    logic [2:0] count;
  } job_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
             (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") begin
      v = c - 8'h30;
    end else if (c >= "a" && c <= "f") begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ced_front.sv =====
`default_nettype none

module ced_front
  import ced_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output job_t            job,
  output logic            push
);

  phase_t     phase, phase_next, phase_mid;
  logic [7:0] digit1, digit1_next;
  logic [7:0] digit2, digit2_next;
  logic [2:0] pre_len;
  logic       fresh;
  logic       main_hit;
  logic [7:0] main_val;

  // Next state and held digits
  always_comb begin
    phase_mid   = phase;
    digit1_next = digit1;
    digit2_next = digit2;
    pre_len     = 3'd0;
    fresh       = 1'b0;
    main_hit    = 1'b0;
    main_val    = in_byte;
    unique case (phase)
      PH_ESC: begin
        if (in_byte == CH_LOW_R) begin
          main_hit = 1'b1; main_val = CH_CR; phase_mid = PH_IDLE;
        end else if (in_byte == CH_LOW_N) begin
          main_hit = 1'b1; main_val = CH_LF; phase_mid = PH_IDLE;
        end else if (in_byte == CH_LOW_T) begin
          main_hit = 1'b1; main_val = CH_TAB; phase_mid = PH_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          main_hit = 1'b1; main_val = CH_BSLASH; phase_mid = PH_IDLE;
        end else if (in_byte == CH_LPAREN) begin
          phase_mid = PH_OPEN;
        end else begin
          pre_len = 3'd1; fresh = 1'b1;
        end
      end
      PH_OPEN: begin
        if (is_hex(in_byte)) begin
          digit1_next = in_byte; phase_mid = PH_HEX1;
        end else begin
          pre_len = 3'd2; fresh = 1'b1;
        end
      end
      PH_HEX1: begin
        if (is_hex(in_byte)) begin
          digit2_next = in_byte; phase_mid = PH_HEX2;
        end else begin
          pre_len = 3'd3; fresh = 1'b1;
        end
      end
      PH_HEX2: begin
        if (in_byte == CH_RPAREN) begin
          main_hit  = 1'b1;
          main_val  = {hex_nibble(digit1), hex_nibble(digit2)};
          phase_mid = PH_IDLE;
        end else begin
          pre_len = 3'd4; fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase
    // byte handled as if nothing were pending
    if (fresh) begin
      if (in_byte == CH_BSLASH) begin
        phase_mid = PH_ESC;
      end else begin
        main_hit  = 1'b1;
        phase_mid = PH_IDLE;
      end
    end
    phase_next = in_last ? PH_IDLE : phase_mid;
  end

  // Job built from this item
  always_comb begin
    job.digit1    = digit1_next;
    job.digit2    = digit2_next;
    job.has_main  = main_hit;
    job.main_byte = main_val;
    job.last      = in_last;
    job.tail_bs   = fresh && in_last && (phase_mid == PH_ESC);
    if (fresh) begin
      job.rep_len = pre_len;
    end else if (in_last) begin
      job.rep_len = phase_mid;
    end else begin
      job.rep_len = 3'd0;
    end
    job.count = job.rep_len + {2'b00, job.has_main} + {2'b00, job.tail_bs};
    push      = accept && (job.count != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digit1 <= digit1_next;
      digit2 <= digit2_next;
    end
  end

`ifndef SYNTH
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> phase == PH_IDLE)
    else $error("phase not idle after end of string");
  a_last_push: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |-> push && job.count <= 3'd5)
    else $error("end of string gave no output job");
`endif

endmodule

`default_nettype wire

// ===== rtl/ced_queue.sv =====
`default_nettype none

module ced_queue
  import ced_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      not_full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign not_full   = count != CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !not_full))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head_valid))
    else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

// ===== rtl/ced_back.sv =====
`default_nettype none

module ced_back
  import ced_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  job_t            head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_malformed,
  output logic            out_end,
  output logic            out_string_end
);

  logic [2:0] idx;
  logic       load;
  logic       is_final;
  logic [7:0] sel_byte;
  logic       sel_bad;

  assign load     = head_valid && (!out_valid || out_ready);
  assign is_final = idx == (head_job.count - 3'd1);
  assign pop      = load && is_final;

  // Pick the byte at position idx of the head job
  always_comb begin
    if (idx < head_job.rep_len) begin
      sel_bad = 1'b1;
      unique case (idx[1:0])
        2'd0:    sel_byte = CH_BSLASH;
        2'd1:    sel_byte = CH_LPAREN;
        2'd2:    sel_byte = head_job.digit1;
        default: sel_byte = head_job.digit2;
      endcase
    end else if (idx == head_job.rep_len && head_job.has_main) begin
      sel_bad  = 1'b0;
      sel_byte = head_job.main_byte;
    end else begin
      sel_bad  = 1'b1;
      sel_byte = CH_BSLASH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= is_final ? 3'd0 : idx + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= sel_byte;
      out_malformed  <= sel_bad;
      out_end        <= is_final;
      out_string_end <= is_final && head_job.last;
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head_job.count)
    else $error("output index past end of job");
  a_str_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_string_end |-> out_end)
    else $error("string end without item end");
`endif

endmodule

`default_nettype wire

// ===== rtl/c_style_escape_decoder.sv =====
`default_nettype none

// Channel | handshake            | payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_ready  | in_byte[7:0], in_last
// out     | out_valid / out_ready| out_byte[7:0], out_malformed, out_end,
//         |                      | out_string_end
//
// One input item is taken per cycle while the job queue has room; the front
// classifies it in the accepting cycle and queues at most one job.
// The back emits one output item per cycle while out_ready is high; an input item
// yields 0 to 5 output items (no job when 0), so a job that expands (escape
// replay) holds the back until all of its items are emitted.
// Path: the job of an accepted item is written into the job queue, and the back
// loads its items from the queue head into the output register.
// Reset (rst, synchronous) empties the queue and output register and
// returns the escape state to idle; held hex digits are not cleared.
// A stalled output fills the queue, then in_ready drops.

module c_style_escape_decoder
  import ced_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_malformed,
  output logic            out_end,
  output logic            out_string_end
);

  logic accept;
  logic push;
  logic pop;
  logic head_valid;
  job_t new_job;
  job_t head_job;

  // Front: escape state machine, one byte per accept
  assign accept = in_valid && in_ready;

  ced_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .job     (new_job),
    .push    (push)
  );

  // Job queue decouples classification from byte emission
  ced_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (new_job),
    .not_full   (in_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: walks each job byte by byte into the output register
  ced_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_malformed  (out_malformed),
    .out_end        (out_end),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire
